>>> src/rch_pkg.sv
// ----------------------------------------------------------------------------
// rch_pkg: shared types and constants for the ray / cylinder hit test
// Fixed-point scale, register map, pipeline depths and width helpers.
// ----------------------------------------------------------------------------
package rch_pkg;

    // Q8.16 coordinates: products of two values carry 2^32, of four 2^64
    localparam int FRAC_BITS       = 16;
    localparam int RCH_SCALE_SHIFT = 2 * FRAC_BITS;
    localparam int RCH_ONE         = 1 << FRAC_BITS;

    // Limb width of the wide multiplier (one hard multiplier per limb pair)
    localparam int RCH_LIMB = 32;

    // Pipeline depths in register stages
    localparam int RCH_MUL_LAT  = 5;
    localparam int RCH_COEF_LAT = 4 + RCH_MUL_LAT;
    localparam int RCH_DEC_LAT  = 1 + RCH_MUL_LAT;
    localparam int RCH_PIPE_LAT = RCH_COEF_LAT + RCH_DEC_LAT;

    // Configuration register map
    localparam int RCH_ADDR_W = 5;
    localparam int RCH_IDX_W  = 3;
    localparam logic [RCH_IDX_W-1:0] RCH_REG_CENTER_X = 3'd0;
    localparam logic [RCH_IDX_W-1:0] RCH_REG_CENTER_Y = 3'd1;
    localparam logic [RCH_IDX_W-1:0] RCH_REG_CENTER_Z = 3'd2;
    localparam logic [RCH_IDX_W-1:0] RCH_REG_AXIS_X   = 3'd3;
    localparam logic [RCH_IDX_W-1:0] RCH_REG_AXIS_Y   = 3'd4;
    localparam logic [RCH_IDX_W-1:0] RCH_REG_AXIS_Z   = 3'd5;
    localparam logic [RCH_IDX_W-1:0] RCH_REG_RADIUS   = 3'd6;

    // Sign and zero flags of the quadratic coefficients
    typedef struct packed {
        logic a_zero;
        logic a_neg;
        logic b_zero;
        logic b_neg;
        logic c_zero;
        logic c_neg;
    } rch_flags_t;

    // Width of a three-term dot product of coordinates (offset has one extra bit)
    function automatic int rch_dot_width(int n);
        return 2 * n + 4;
    endfunction

    // Width of a, b/2 and c: the larger of the squared dot and the scaled dot
    function automatic int rch_coef_width(int n);
        int dw;
        dw = rch_dot_width(n);
        return ((2 * dw > dw + RCH_SCALE_SHIFT) ? 2 * dw : dw + RCH_SCALE_SHIFT) + 2;
    endfunction

endpackage

>>> src/ray_cylinder_hit_test.sv
// An accepted input beat passes the pipeline and the output register to m_*.
// Throughput: one ray per cycle while s_ready holds; the 15-stage arithmetic
// pipeline and output register move together when the last stage can hand on.
// Reset: aresetn, synchronous, active low; clears the valid bits, the output
// valid and the cylinder registers (centre 0, axis (0, 1.0, 0), radius 1.0).
// ----------------------------------------------------------------------------
// ray_cylinder_hit_test: ray against infinite cylinder hit test
// Exact fixed-point evaluation of the quadratic coefficients, the sign of
// the discriminant and the root signs, one ray per cycle unless stalled.
// ----------------------------------------------------------------------------
module ray_cylinder_hit_test
    import rch_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // Ray channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_origin_x,
    input  logic signed [COORD_BITS-1:0] s_origin_y,
    input  logic signed [COORD_BITS-1:0] s_origin_z,
    input  logic signed [COORD_BITS-1:0] s_dir_x,
    input  logic signed [COORD_BITS-1:0] s_dir_y,
    input  logic signed [COORD_BITS-1:0] s_dir_z,

    // Result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,

    // Register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [RCH_ADDR_W-1:0]        paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int CW = rch_coef_width(COORD_BITS);

    // Cylinder registers
    logic signed [COORD_BITS-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic signed [COORD_BITS-1:0] axis_x_reg, axis_y_reg, axis_z_reg;
    logic        [COORD_BITS-2:0] radius_reg;

    logic                 cfg_wr;
    logic [RCH_IDX_W-1:0] cfg_idx;

    // Pipeline control
    logic [RCH_PIPE_LAT-1:0] vld_reg;
    logic                    pipe_en;
    logic                    out_load;
    logic                    out_valid_reg;
    logic                    m_hit_reg;

    logic signed [CW-1:0] coef_a, coef_b, coef_c;
    logic                 dec_hit;

    // ------------------------------------------------------------------
    // Register port: write in the access phase, no wait states
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[RCH_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            axis_x_reg   <= '0;
            axis_y_reg   <= COORD_BITS'(RCH_ONE);
            axis_z_reg   <= '0;
            radius_reg   <= (COORD_BITS-1)'(RCH_ONE);
        end else if (cfg_wr) begin
            case (cfg_idx)
                RCH_REG_CENTER_X: center_x_reg <= pwdata[COORD_BITS-1:0];
                RCH_REG_CENTER_Y: center_y_reg <= pwdata[COORD_BITS-1:0];
                RCH_REG_CENTER_Z: center_z_reg <= pwdata[COORD_BITS-1:0];
                RCH_REG_AXIS_X:   axis_x_reg   <= pwdata[COORD_BITS-1:0];
                RCH_REG_AXIS_Y:   axis_y_reg   <= pwdata[COORD_BITS-1:0];
                RCH_REG_AXIS_Z:   axis_z_reg   <= pwdata[COORD_BITS-1:0];
                RCH_REG_RADIUS:   radius_reg   <= pwdata[COORD_BITS-2:0];
                default: ;  // beyond the map: drop the write
            endcase
        end
    end

    // Read back sign-extended coordinates, zero-extended radius
    always_comb begin
        case (cfg_idx)
            RCH_REG_CENTER_X: prdata = 32'(center_x_reg);
            RCH_REG_CENTER_Y: prdata = 32'(center_y_reg);
            RCH_REG_CENTER_Z: prdata = 32'(center_z_reg);
            RCH_REG_AXIS_X:   prdata = 32'(axis_x_reg);
            RCH_REG_AXIS_Y:   prdata = 32'(axis_y_reg);
            RCH_REG_AXIS_Z:   prdata = 32'(axis_z_reg);
            RCH_REG_RADIUS:   prdata = 32'(radius_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Flow control
    // The whole pipeline advances together. Hold it only when the last
    // stage carries a result and the output register cannot take it; a
    // bubble in the last stage lets new beats in while a result waits.
    // ------------------------------------------------------------------
    assign out_load = m_ready || !out_valid_reg;
    assign pipe_en  = !vld_reg[RCH_PIPE_LAT-1] || out_load;
    assign s_ready  = pipe_en;

    // Valid bits ride alongside the data, one per stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[RCH_PIPE_LAT-2:0], s_valid};
        end
    end

    // Output register: advance on an empty slot or a taken beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= vld_reg[RCH_PIPE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_hit_reg <= dec_hit;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_hit   = m_hit_reg;

    // ------------------------------------------------------------------
    // Datapath: coefficients (9 stages), then decision (6 stages)
    // ------------------------------------------------------------------
    rch_coef #(.N(COORD_BITS)) u_coef (
        .aclk     (aclk),
        .en       (pipe_en),
        .origin_x (s_origin_x),
        .origin_y (s_origin_y),
        .origin_z (s_origin_z),
        .dir_x    (s_dir_x),
        .dir_y    (s_dir_y),
        .dir_z    (s_dir_z),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .center_z (center_z_reg),
        .axis_x   (axis_x_reg),
        .axis_y   (axis_y_reg),
        .axis_z   (axis_z_reg),
        .radius   (radius_reg),
        .coef_a   (coef_a),
        .coef_b   (coef_b),
        .coef_c   (coef_c)
    );

    rch_decide #(.CW(CW)) u_decide (
        .aclk   (aclk),
        .en     (pipe_en),
        .coef_a (coef_a),
        .coef_b (coef_b),
        .coef_c (coef_c),
        .hit    (dec_hit)
    );

endmodule

>>> src/rch_mul.sv
// ----------------------------------------------------------------------------
// rch_mul: pipelined wide signed multiplier
// Splits magnitudes into 32-bit limbs, forms all limb products, sums each row
// and the rows, restores the sign. Five stages, one product per enabled cycle.
// ----------------------------------------------------------------------------
module rch_mul
    import rch_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [AW-1:0]  a,
    input  logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0] p
);

    localparam int PW    = AW + BW;
    localparam int NA    = (AW + RCH_LIMB - 1) / RCH_LIMB;
    localparam int NB    = (BW + RCH_LIMB - 1) / RCH_LIMB;
    localparam int AMW   = NA * RCH_LIMB;
    localparam int BMW   = NB * RCH_LIMB;
    localparam int PPW   = 2 * RCH_LIMB;
    localparam int ROW_W = (NB + 1) * RCH_LIMB;
    localparam int SUM_W = (NA + NB) * RCH_LIMB;

    logic [AW-1:0]  abs_a;
    logic [BW-1:0]  abs_b;
    logic [AMW-1:0] mag_a_reg, mag_a_next;
    logic [BMW-1:0] mag_b_reg, mag_b_next;
    logic [RCH_MUL_LAT-2:0] neg_reg, neg_next;
    logic [PPW-1:0]   pp_reg  [NA][NB];
    logic [PPW-1:0]   pp_next [NA][NB];
    logic [ROW_W-1:0] row_reg  [NA];
    logic [ROW_W-1:0] row_next [NA];
    logic [PW-1:0]  mag_reg, mag_next;
    logic [PW-1:0]  p_reg, p_next;

    // Stage 1: magnitudes and product sign
    assign abs_a      = a[AW-1] ? $unsigned(-a) : $unsigned(a);
    assign abs_b      = b[BW-1] ? $unsigned(-b) : $unsigned(b);
    assign mag_a_next = AMW'(abs_a);
    assign mag_b_next = BMW'(abs_b);
    assign neg_next   = {neg_reg[RCH_MUL_LAT-3:0], a[AW-1] ^ b[BW-1]};

    // Stage 2: limb products
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                pp_next[i][j] = PPW'(mag_a_reg[i*RCH_LIMB +: RCH_LIMB])
                              * PPW'(mag_b_reg[j*RCH_LIMB +: RCH_LIMB]);
            end
        end
    end

    // Stage 3: one row per limb of a
    always_comb begin : row_sum
        logic [ROW_W-1:0] acc;
        for (int i = 0; i < NA; i++) begin
            acc = '0;
            for (int j = 0; j < NB; j++) begin
                acc = acc + (ROW_W'(pp_reg[i][j]) << (RCH_LIMB * j));
            end
            row_next[i] = acc;
        end
    end

    // Stage 4: rows into the full magnitude
    always_comb begin : col_sum
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            acc = acc + (SUM_W'(row_reg[i]) << (RCH_LIMB * i));
        end
        mag_next = PW'(acc);
    end

    // Stage 5: restore the sign
    assign p_next = neg_reg[RCH_MUL_LAT-2] ? (~mag_reg + PW'(1)) : mag_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
            neg_reg   <= neg_next;
            pp_reg    <= pp_next;
            row_reg   <= row_next;
            mag_reg   <= mag_next;
            p_reg     <= p_next;
        end
    end

    assign p = $signed(p_reg);

endmodule

>>> src/rch_coef.sv
// ----------------------------------------------------------------------------
// rch_coef: quadratic coefficient pipeline
// Forms a = d.d*2^32 - (u.d)^2, b/2 = oc.d*2^32 - (u.oc)(u.d) and
// c = oc.oc*2^32 - (u.oc)^2 - r^2*2^32 exactly, in nine stages.
// ----------------------------------------------------------------------------
module rch_coef
    import rch_pkg::*;
#(
    parameter int N = 24
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [N-1:0]   origin_x,
    input  logic signed [N-1:0]   origin_y,
    input  logic signed [N-1:0]   origin_z,
    input  logic signed [N-1:0]   dir_x,
    input  logic signed [N-1:0]   dir_y,
    input  logic signed [N-1:0]   dir_z,
    input  logic signed [N-1:0]   center_x,
    input  logic signed [N-1:0]   center_y,
    input  logic signed [N-1:0]   center_z,
    input  logic signed [N-1:0]   axis_x,
    input  logic signed [N-1:0]   axis_y,
    input  logic signed [N-1:0]   axis_z,
    input  logic        [N-2:0]   radius,
    output logic signed [rch_coef_width(N)-1:0] coef_a,
    output logic signed [rch_coef_width(N)-1:0] coef_b,
    output logic signed [rch_coef_width(N)-1:0] coef_c
);

    localparam int OW    = N + 1;
    localparam int P1_W  = 2 * N + 2;
    localparam int RR_W  = 2 * N - 2;
    localparam int DOT_W = rch_dot_width(N);
    localparam int SQ_W  = 2 * DOT_W;
    localparam int CW    = rch_coef_width(N);

    // Stage 1: offset from the centre
    logic signed [OW-1:0] oc_reg [3];
    logic signed [OW-1:0] oc_next [3];
    logic signed [N-1:0]  d_reg [3];
    logic signed [N-1:0]  u_reg [3];
    logic        [N-2:0]  r_reg;

    // Stage 2: coordinate products
    logic signed [P1_W-1:0] ud_p_reg [3], ud_p_next [3];
    logic signed [P1_W-1:0] uo_p_reg [3], uo_p_next [3];
    logic signed [P1_W-1:0] dd_p_reg [3], dd_p_next [3];
    logic signed [P1_W-1:0] od_p_reg [3], od_p_next [3];
    logic signed [P1_W-1:0] oo_p_reg [3], oo_p_next [3];
    logic        [RR_W-1:0] rr_reg, rr_next;

    // Stage 3: dot products
    logic signed [DOT_W-1:0] ud_reg, ud_next;
    logic signed [DOT_W-1:0] uo_reg, uo_next;
    logic signed [DOT_W-1:0] dd_reg, dd_next;
    logic signed [DOT_W-1:0] od_reg, od_next;
    logic signed [DOT_W-1:0] oo_reg, oo_next;
    logic        [RR_W-1:0]  rr3_reg;

    // Stages 4..8: products of the axis projections, scaled terms delayed alongside
    logic signed [SQ_W-1:0]  udud, uoud, uouo;
    logic signed [DOT_W-1:0] dd_dly_reg [RCH_MUL_LAT];
    logic signed [DOT_W-1:0] od_dly_reg [RCH_MUL_LAT];
    logic signed [DOT_W-1:0] oo_dly_reg [RCH_MUL_LAT];
    logic        [RR_W-1:0]  rr_dly_reg [RCH_MUL_LAT];

    // Stage 9: coefficients
    logic signed [CW-1:0] a_reg, a_next;
    logic signed [CW-1:0] b_reg, b_next;
    logic signed [CW-1:0] c_reg, c_next;

    assign oc_next[0] = OW'(origin_x) - OW'(center_x);
    assign oc_next[1] = OW'(origin_y) - OW'(center_y);
    assign oc_next[2] = OW'(origin_z) - OW'(center_z);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ud_p_next[i] = P1_W'(u_reg[i])  * P1_W'(d_reg[i]);
            uo_p_next[i] = P1_W'(u_reg[i])  * P1_W'(oc_reg[i]);
            dd_p_next[i] = P1_W'(d_reg[i])  * P1_W'(d_reg[i]);
            od_p_next[i] = P1_W'(oc_reg[i]) * P1_W'(d_reg[i]);
            oo_p_next[i] = P1_W'(oc_reg[i]) * P1_W'(oc_reg[i]);
        end
    end
    assign rr_next = RR_W'(r_reg) * RR_W'(r_reg);

    assign ud_next = DOT_W'(ud_p_reg[0]) + DOT_W'(ud_p_reg[1]) + DOT_W'(ud_p_reg[2]);
    assign uo_next = DOT_W'(uo_p_reg[0]) + DOT_W'(uo_p_reg[1]) + DOT_W'(uo_p_reg[2]);
    assign dd_next = DOT_W'(dd_p_reg[0]) + DOT_W'(dd_p_reg[1]) + DOT_W'(dd_p_reg[2]);
    assign od_next = DOT_W'(od_p_reg[0]) + DOT_W'(od_p_reg[1]) + DOT_W'(od_p_reg[2]);
    assign oo_next = DOT_W'(oo_p_reg[0]) + DOT_W'(oo_p_reg[1]) + DOT_W'(oo_p_reg[2]);

    rch_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_udud (
        .aclk (aclk),
        .en   (en),
        .a    (ud_reg),
        .b    (ud_reg),
        .p    (udud)
    );

    rch_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_uoud (
        .aclk (aclk),
        .en   (en),
        .a    (uo_reg),
        .b    (ud_reg),
        .p    (uoud)
    );

    rch_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_uouo (
        .aclk (aclk),
        .en   (en),
        .a    (uo_reg),
        .b    (uo_reg),
        .p    (uouo)
    );

    assign a_next = (CW'(dd_dly_reg[RCH_MUL_LAT-1]) <<< RCH_SCALE_SHIFT) - CW'(udud);
    assign b_next = (CW'(od_dly_reg[RCH_MUL_LAT-1]) <<< RCH_SCALE_SHIFT) - CW'(uoud);
    assign c_next = (CW'(oo_dly_reg[RCH_MUL_LAT-1]) <<< RCH_SCALE_SHIFT) - CW'(uouo)
                  - $signed(CW'(rr_dly_reg[RCH_MUL_LAT-1]) << RCH_SCALE_SHIFT);

    always_ff @(posedge aclk) begin
        if (en) begin
            oc_reg <= oc_next;
            d_reg[0] <= dir_x;
            d_reg[1] <= dir_y;
            d_reg[2] <= dir_z;
            u_reg[0] <= axis_x;
            u_reg[1] <= axis_y;
            u_reg[2] <= axis_z;
            r_reg    <= radius;

            ud_p_reg <= ud_p_next;
            uo_p_reg <= uo_p_next;
            dd_p_reg <= dd_p_next;
            od_p_reg <= od_p_next;
            oo_p_reg <= oo_p_next;
            rr_reg   <= rr_next;

            ud_reg  <= ud_next;
            uo_reg  <= uo_next;
            dd_reg  <= dd_next;
            od_reg  <= od_next;
            oo_reg  <= oo_next;
            rr3_reg <= rr_reg;

            dd_dly_reg[0] <= dd_reg;
            od_dly_reg[0] <= od_reg;
            oo_dly_reg[0] <= oo_reg;
            rr_dly_reg[0] <= rr3_reg;
            for (int k = 1; k < RCH_MUL_LAT; k++) begin
                dd_dly_reg[k] <= dd_dly_reg[k-1];
                od_dly_reg[k] <= od_dly_reg[k-1];
                oo_dly_reg[k] <= oo_dly_reg[k-1];
                rr_dly_reg[k] <= rr_dly_reg[k-1];
            end

            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    assign coef_a = a_reg;
    assign coef_b = b_reg;
    assign coef_c = c_reg;

endmodule

>>> src/rch_decide.sv
// ----------------------------------------------------------------------------
// rch_decide: discriminant and root-sign decision
// Squares b/2, multiplies a by c, and decides the hit from the sign of the
// difference and the signs of a, b and c. Six stages.
// ----------------------------------------------------------------------------
module rch_decide
    import rch_pkg::*;
#(
    parameter int CW = 104
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [CW-1:0] coef_a,
    input  logic signed [CW-1:0] coef_b,
    input  logic signed [CW-1:0] coef_c,
    output logic                 hit
);

    localparam int PW = 2 * CW;
    localparam int DW = PW + 1;

    logic signed [PW-1:0] bb, ac;
    logic signed [DW-1:0] disc;
    logic                 disc_neg;
    logic                 ab_pos, ac_pos;
    rch_flags_t flg_next;
    rch_flags_t flg_reg [RCH_MUL_LAT];
    rch_flags_t flg;
    logic       hit_reg, hit_next;

    // Sign of the discriminant follows (b/2)^2 - a*c
    rch_mul #(.AW(CW), .BW(CW)) u_mul_bb (
        .aclk (aclk),
        .en   (en),
        .a    (coef_b),
        .b    (coef_b),
        .p    (bb)
    );

    rch_mul #(.AW(CW), .BW(CW)) u_mul_ac (
        .aclk (aclk),
        .en   (en),
        .a    (coef_a),
        .b    (coef_c),
        .p    (ac)
    );

    always_comb begin
        flg_next.a_zero = (coef_a == '0);
        flg_next.a_neg  = coef_a[CW-1];
        flg_next.b_zero = (coef_b == '0);
        flg_next.b_neg  = coef_b[CW-1];
        flg_next.c_zero = (coef_c == '0);
        flg_next.c_neg  = coef_c[CW-1];
    end

    assign flg      = flg_reg[RCH_MUL_LAT-1];
    assign disc     = DW'(bb) - DW'(ac);
    assign disc_neg = disc[DW-1];
    // Both roots negative exactly when a*b > 0 and a*c > 0
    assign ab_pos   = !flg.b_zero && (flg.b_neg == flg.a_neg);
    assign ac_pos   = !flg.c_zero && (flg.c_neg == flg.a_neg);

    always_comb begin
        if (flg.a_zero) begin
            // parallel to the axis: hit when the origin is inside or on the wall
            hit_next = flg.c_neg || flg.c_zero;
        end else if (disc_neg) begin
            hit_next = 1'b0;
        end else begin
            hit_next = !(ab_pos && ac_pos);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flg_reg[0] <= flg_next;
            for (int k = 1; k < RCH_MUL_LAT; k++) begin
                flg_reg[k] <= flg_reg[k-1];
            end
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

>>> src/rch_checker.sv
// ----------------------------------------------------------------------------
// rch_checker: port-level checks for the ray / cylinder hit test
// Tracks beats in flight and checks flow control at the ports.
// ----------------------------------------------------------------------------
module rch_checker
    import rch_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_hit
);

    localparam int CNT_W = $clog2(RCH_PIPE_LAT + 2) + 1;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_beat, out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;
    assign cnt_next = cnt_reg + CNT_W'(in_beat) - CNT_W'(out_beat);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit))
        else $error("result beat changed while stalled");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // No result without a ray in flight; at most one per stage and output register
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cnt_reg != '0)
        else $error("result beat with no ray in flight");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(RCH_PIPE_LAT + 1))
        else $error("more rays in flight than pipeline stages");

    // A ready sink never stalls the source
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input held off while output is ready");

endmodule

bind ray_cylinder_hit_test rch_checker u_rch_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_hit   (m_hit)
);
